// ===== hdl/lrm_pkg.sv =====
// Shared types, constants and helpers for the letter reachability matcher.
`timescale 1ns / 1ps

package lrm_pkg;

  localparam int LETTERS  = 26;
  localparam int IDX_W    = $clog2(LETTERS);
  localparam int LETTER_W = 5;
  localparam int FUNC_W   = 2;

  typedef logic [LETTERS-1:0]  row_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [FUNC_W-1:0]   func_t;

  localparam func_t FUNC_EDGE  = 2'd0;
  localparam func_t FUNC_QUERY = 2'd1;
  localparam func_t FUNC_CLEAR = 2'd2;

  localparam idx_t LAST_IDX = idx_t'(LETTERS - 1);

  function automatic logic letter_ok(input letter_t l);
    return int'(l) < LETTERS;
  endfunction

  function automatic idx_t to_idx(input letter_t l);
    return idx_t'(l);
  endfunction

endpackage

// ===== hdl/lrm_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module lrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/letter_reachability_matcher.sv =====
// Top level of the letter reachability matcher: request decode, closure sequencer, verdict.
`timescale 1ns / 1ps

// Keeps a directed graph over LETTERS letters in an edge RAM and its transitive
// closure in a reach RAM. A request is taken when start is high and busy is low.
// An in-range edge request reads, modifies and writes back one edge row; a clear
// request drops the per-row valid bits at once. A query pair whose letters are
// equal or out of range settles at accept; otherwise it reads one closure row.
// The first query that needs the graph after any in-range edge or any clear
// request first rebuilds the closure, one row per read/write pair on the single
// reach RAM, before its lookup. A last pair gives one verdict, shown with done
// high for exactly one cycle; there is no way to hold it off, so capture it when
// done is high. A new request may be taken in the same cycle the verdict is shown.
module letter_reachability_matcher
  import lrm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  func_t   func,
  input  letter_t source_letter,
  input  letter_t target_letter,
  input  logic    last_pair,
  input  logic    lengths_equal,
  output logic    done,
  output logic    verdict
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE_WR,
    S_COPY_RD,
    S_COPY_WR,
    S_K_RD,
    S_K_LATCH,
    S_I_RD,
    S_I_WR,
    S_LOOK_RD,
    S_LOOK
  } state_t;

  state_t state;

  // Held request fields
  idx_t src_idx;
  idx_t tgt_idx;
  logic last_q;
  logic leneq_q;

  // Graph bookkeeping
  row_t edge_valid;
  logic stale;
  logic word_ok;

  // Closure sweep counters and pivot row
  idx_t k;
  idx_t i;
  row_t krow;

  // RAM ports
  logic e_we;
  idx_t e_waddr;
  row_t e_wdata;
  idx_t e_raddr;
  row_t e_rdata;
  logic r_we;
  idx_t r_waddr;
  row_t r_wdata;
  idx_t r_raddr;
  row_t r_rdata;

  lrm_ram #(.WIDTH(LETTERS), .DEPTH(LETTERS)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  lrm_ram #(.WIDTH(LETTERS), .DEPTH(LETTERS)) u_reach_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  logic accept;
  logic in_src_ok;
  logic in_tgt_ok;
  logic in_eq;
  logic need_graph;

  // Pair finish: a match decided either at accept or after the closure lookup
  logic fin;
  logic fin_match;
  logic fin_last;
  logic fin_leneq;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign in_src_ok = letter_ok(source_letter);
  assign in_tgt_ok = letter_ok(target_letter);
  assign in_eq     = (source_letter == target_letter);
  assign need_graph = !in_eq && in_src_ok && in_tgt_ok;

  always_comb begin
    e_we    = 1'b0;
    e_waddr = src_idx;
    e_wdata = (edge_valid[src_idx] ? e_rdata : '0) | (row_t'(1) << tgt_idx);
    e_raddr = to_idx(source_letter);
    r_we    = 1'b0;
    r_waddr = i;
    r_wdata = r_rdata | krow;
    r_raddr = to_idx(source_letter);
    fin       = 1'b0;
    fin_match = 1'b0;
    fin_last  = last_q;
    fin_leneq = leneq_q;
    case (state)
      S_IDLE: begin
        // Equal letters or out-of-range letters settle at once
        if (accept && func == FUNC_QUERY && !need_graph) begin
          fin       = 1'b1;
          fin_match = in_eq;
          fin_last  = last_pair;
          fin_leneq = lengths_equal;
        end
      end
      S_EDGE_WR: begin
        e_we = 1'b1;
      end
      S_COPY_RD: begin
        e_raddr = i;
      end
      S_COPY_WR: begin
        // Seed the closure with the edge row; an invalid row reads as empty
        r_we    = 1'b1;
        r_wdata = edge_valid[i] ? e_rdata : '0;
      end
      S_K_RD: begin
        r_raddr = k;
      end
      S_I_RD: begin
        r_raddr = i;
      end
      S_I_WR: begin
        r_we = r_rdata[k];
      end
      S_LOOK_RD: begin
        r_raddr = src_idx;
      end
      S_LOOK: begin
        fin       = 1'b1;
        fin_match = r_rdata[tgt_idx];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      edge_valid <= '0;
      stale      <= 1'b1;
      word_ok    <= 1'b1;
      done       <= 1'b0;
      verdict    <= 1'b0;
      src_idx    <= '0;
      tgt_idx    <= '0;
      last_q     <= 1'b0;
      leneq_q    <= 1'b0;
      k          <= '0;
      i          <= '0;
      krow       <= '0;
    end else begin
      done <= 1'b0;

      // Close out a query pair: emit on the last pair, else track mismatches
      if (fin) begin
        if (fin_last) begin
          done    <= 1'b1;
          verdict <= word_ok && fin_match && fin_leneq;
          word_ok <= 1'b1;
        end else if (!fin_match) begin
          word_ok <= 1'b0;
        end
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            src_idx <= to_idx(source_letter);
            tgt_idx <= to_idx(target_letter);
            last_q  <= last_pair;
            leneq_q <= lengths_equal;
            case (func)
              FUNC_EDGE: begin
                // Edge row read is already in flight; write back next cycle
                if (in_src_ok && in_tgt_ok) begin
                  stale <= 1'b1;
                  state <= S_EDGE_WR;
                end
              end
              FUNC_CLEAR: begin
                edge_valid <= '0;
                stale      <= 1'b1;
              end
              FUNC_QUERY: begin
                if (need_graph) begin
                  if (stale) begin
                    i     <= '0;
                    state <= S_COPY_RD;
                  end else begin
                    // Closure row read is already in flight
                    state <= S_LOOK;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_EDGE_WR: begin
          edge_valid[src_idx] <= 1'b1;
          state               <= S_IDLE;
        end
        S_COPY_RD: begin
          state <= S_COPY_WR;
        end
        S_COPY_WR: begin
          if (i == LAST_IDX) begin
            k     <= '0;
            state <= S_K_RD;
          end else begin
            i     <= i + idx_t'(1);
            state <= S_COPY_RD;
          end
        end
        S_K_RD: begin
          state <= S_K_LATCH;
        end
        S_K_LATCH: begin
          // Hold the pivot row for the whole pass; ORing it into itself changes nothing
          krow  <= r_rdata;
          i     <= '0;
          state <= S_I_RD;
        end
        S_I_RD: begin
          state <= S_I_WR;
        end
        S_I_WR: begin
          if (i == LAST_IDX) begin
            if (k == LAST_IDX) begin
              stale <= 1'b0;
              state <= S_LOOK_RD;
            end else begin
              k     <= k + idx_t'(1);
              state <= S_K_RD;
            end
          end else begin
            i     <= i + idx_t'(1);
            state <= S_I_RD;
          end
        end
        S_LOOK_RD: begin
          state <= S_LOOK;
        end
        S_LOOK: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the letter reachability matcher: directed and random requests.
`timescale 1ns / 1ps

// The testbench drives requests on the command interface at the falling edge
// and samples busy, done and verdict at the rising edge.
//
// A behavioral graph model runs beside the block. It holds its own edge
// matrix, closure, stale flag, word flag and edge counter. Each accepted
// request is applied to the model at the edge that accepts it. A last query
// pair pushes one expected verdict onto a queue. The monitor pops the oldest
// entry on every done strobe and compares it with the verdict port.
//
// Stimulus order:
//   - directed tests for the empty graph, chains of edges, duplicate edges,
//     letters out of range, the unused func code, a clear inside a word,
//     a failed middle pair and unequal lengths;
//   - a long run of edges, so that the edge counter saturates;
//   - random phases, each built from graph bursts: an optional clear, a few
//     edges, then whole words. Word pairs lean toward reachable letter pairs
//     so that yes verdicts are common. Some noise is mixed in: the unused
//     func code, edges and clears inside a word, and letters out of range.
// The phases differ in how often the sender idles. done cannot be held off,
// so no receiver stall exists.
module tb_top;
  import lrm_pkg::*;

  // func code the block ignores
  localparam func_t FUNC_UNUSED = 2'd3;

  typedef logic [LETTERS-1:0][LETTERS-1:0] matrix_t;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  func_t   func;
  letter_t source_letter;
  letter_t target_letter;
  logic    last_pair;
  logic    lengths_equal;
  logic    done;
  logic    verdict;

  // graph model state
  matrix_t    model_edges;
  matrix_t    model_reach;
  logic       model_stale;
  logic       model_word_ok;
  logic [9:0] model_edge_count;

  bit verdict_q[$];   // verdicts still owed by the block, oldest first
  int mismatches;
  int idle_pct;       // chance in percent that the sender idles before a request
  int request_count;  // accepted requests so far

  letter_reachability_matcher u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .source_letter (source_letter),
    .target_letter (target_letter),
    .last_pair     (last_pair),
    .lengths_equal (lengths_equal),
    .done          (done),
    .verdict       (verdict)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs on busy or never reports.
  initial begin
    #(100_000_000);
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Warshall pass: after it, row i holds every letter reachable from i
  // through one or more edges.
  function automatic matrix_t closure_of(input matrix_t g);
    matrix_t r;
    r = g;
    for (int k = 0; k < LETTERS; k++) begin
      for (int i = 0; i < LETTERS; i++) begin
        if (r[i][k]) begin
          r[i] = r[i] | r[k];
        end
      end
    end
    return r;
  endfunction

  function automatic logic in_alphabet(input letter_t l);
    return int'(l) < LETTERS;
  endfunction

  // Advance the graph model by one accepted request; queue a verdict on a
  // last query pair.
  task automatic apply_request(input func_t f, input letter_t s, input letter_t t,
                               input logic last, input logic leq);
    logic pair_hit;
    case (f)
      FUNC_EDGE: begin
        // drop edges that name a letter outside the alphabet
        if (in_alphabet(s) && in_alphabet(t)) begin
          model_edges[s][t] = 1'b1;
          model_stale = 1'b1;
          if (model_edge_count != 10'h3ff) begin
            model_edge_count = model_edge_count + 10'd1;
          end
        end
      end
      FUNC_CLEAR: begin
        // empty the graph; leave the word flag alone
        model_edges = '0;
        model_stale = 1'b1;
        model_edge_count = '0;
      end
      FUNC_QUERY: begin
        pair_hit = (s == t);
        if (!pair_hit && in_alphabet(s) && in_alphabet(t)) begin
          if (model_stale) begin
            model_reach = closure_of(model_edges);
            model_stale = 1'b0;
          end
          pair_hit = model_reach[s][t];
        end
        if (last) begin
          verdict_q = {verdict_q, bit'(model_word_ok && pair_hit && leq)};
          model_word_ok = 1'b1;
        end else if (!pair_hit) begin
          model_word_ok = 1'b0;
        end
      end
      default: begin
        // unused code: no state change, no verdict
      end
    endcase
  endtask

  // Send one request. Called and returns at a falling edge; start stays high
  // on return so that back-to-back requests need no lowering of start.
  task automatic send_request(input func_t f, input letter_t s, input letter_t t,
                              input logic last, input logic leq);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start         = 1'b1;
    func          = f;
    source_letter = s;
    target_letter = t;
    last_pair     = last;
    lengths_equal = leq;
    // hold the request until an edge with busy low takes it
    do begin
      @(posedge clk);
    end while (busy);
    apply_request(f, s, t, last, leq);
    request_count++;
    @(negedge clk);
  endtask

  // Compare each verdict strobe with the oldest owed verdict.
  always @(posedge clk) begin
    bit want;
    if (!rst && done) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("verdict %0b strobed with none owed", verdict));
      end else begin
        want = verdict_q.pop_front();
        if (verdict !== want) begin
          report_mismatch($sformatf("verdict %0b, model gives %0b", verdict, want));
        end
      end
    end
  end

  // Mostly a small set of letters so that graphs get dense, sometimes the
  // whole alphabet, now and then any 5-bit code.
  function automatic letter_t pick_letter();
    int r;
    r = $urandom_range(99);
    if (r < 70) begin
      return letter_t'($urandom_range(7));
    end else if (r < 90) begin
      return letter_t'($urandom_range(LETTERS - 1));
    end
    return letter_t'($urandom_range(31));
  endfunction

  // Pick the second letter of a pair; lean toward letters the source reaches.
  function automatic letter_t pick_target(input letter_t src);
    matrix_t r;
    letter_t hits[$];
    if (!in_alphabet(src)) begin
      return $urandom_range(1) ? src : pick_letter();
    end
    if ($urandom_range(99) < 15) begin
      return src;
    end
    if ($urandom_range(99) < 40) begin
      return pick_letter();
    end
    r = closure_of(model_edges);
    for (int j = 0; j < LETTERS; j++) begin
      if (r[src][j]) begin
        hits = {hits, letter_t'(j)};
      end
    end
    if (hits.size() == 0) begin
      return pick_letter();
    end
    return hits[$urandom_range(hits.size() - 1)];
  endfunction

  task automatic test_empty_graph();
    send_request(FUNC_QUERY, 5'd0, 5'd0, 1'b1, 1'b1);    // equal letters: yes
    send_request(FUNC_QUERY, 5'd0, 5'd1, 1'b1, 1'b1);    // no edges yet: no
    send_request(FUNC_QUERY, 5'd25, 5'd25, 1'b1, 1'b0);  // lengths differ: no
  endtask

  task automatic test_chain_reachability();
    send_request(FUNC_EDGE, 5'd0, 5'd1, 1'b0, 1'b0);
    send_request(FUNC_EDGE, 5'd1, 5'd2, 1'b1, 1'b1);
    send_request(FUNC_EDGE, 5'd2, 5'd25, 1'b0, 1'b1);
    send_request(FUNC_EDGE, 5'd2, 5'd25, 1'b1, 1'b0);    // duplicate edge
    send_request(FUNC_QUERY, 5'd0, 5'd25, 1'b1, 1'b1);   // three hops: yes
    send_request(FUNC_QUERY, 5'd25, 5'd0, 1'b1, 1'b1);   // wrong direction: no
    send_request(FUNC_QUERY, 5'd1, 5'd1, 1'b0, 1'b0);
    send_request(FUNC_QUERY, 5'd1, 5'd25, 1'b1, 1'b1);   // two-pair word: yes
  endtask

  task automatic test_out_of_range_and_unused();
    send_request(FUNC_EDGE, 5'd31, 5'd0, 1'b0, 1'b0);    // ignored
    send_request(FUNC_EDGE, 5'd0, 5'd26, 1'b0, 1'b0);    // ignored
    send_request(FUNC_UNUSED, 5'd31, 5'd31, 1'b1, 1'b1); // ignored, no verdict
    send_request(FUNC_QUERY, 5'd31, 5'd31, 1'b1, 1'b1);  // equal codes: yes
    send_request(FUNC_QUERY, 5'd31, 5'd0, 1'b1, 1'b1);   // no
    send_request(FUNC_QUERY, 5'd26, 5'd27, 1'b1, 1'b1);  // no
  endtask

  task automatic test_clear_mid_word();
    send_request(FUNC_QUERY, 5'd0, 5'd2, 1'b0, 1'b0);    // matches through edges
    send_request(FUNC_CLEAR, 5'd0, 5'd0, 1'b0, 1'b0);
    send_request(FUNC_QUERY, 5'd3, 5'd3, 1'b1, 1'b1);    // word carries on: yes
    send_request(FUNC_QUERY, 5'd0, 5'd1, 1'b1, 1'b1);    // graph gone: no
  endtask

  task automatic test_failed_word();
    send_request(FUNC_EDGE, 5'd4, 5'd5, 1'b0, 1'b0);
    send_request(FUNC_QUERY, 5'd4, 5'd5, 1'b0, 1'b1);
    send_request(FUNC_QUERY, 5'd5, 5'd4, 1'b0, 1'b1);    // fails
    send_request(FUNC_QUERY, 5'd4, 5'd5, 1'b1, 1'b1);    // word no
    send_request(FUNC_QUERY, 5'd4, 5'd5, 1'b1, 1'b1);    // fresh word: yes
  endtask

  // Drive the edge counter past its ceiling, then check the graph still works.
  task automatic test_edge_count_saturation();
    send_request(FUNC_CLEAR, 5'd0, 5'd0, 1'b0, 1'b0);
    for (int n = 0; n < 1030; n++) begin
      send_request(FUNC_EDGE, letter_t'($urandom_range(3)), letter_t'($urandom_range(3)),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    for (int n = 0; n < 6; n++) begin
      send_request(FUNC_QUERY, letter_t'($urandom_range(4)), letter_t'($urandom_range(4)),
                   1'b1, 1'b1);
    end
  endtask

  // Random graph bursts followed by whole words, with noise mixed in.
  task automatic run_random_bursts(input int n_requests);
    int goal;
    int n_edges;
    int n_words;
    int word_len;
    int r;
    letter_t src;
    logic last;
    logic leq;
    goal = request_count + n_requests;
    while (request_count < goal) begin
      if ($urandom_range(99) < 20) begin
        send_request(FUNC_CLEAR, pick_letter(), pick_letter(),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      n_edges = $urandom_range(1, 6);
      for (int e = 0; e < n_edges; e++) begin
        send_request(FUNC_EDGE, pick_letter(), pick_letter(),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      n_words = $urandom_range(1, 5);
      for (int w = 0; w < n_words; w++) begin
        word_len = $urandom_range(1, 5);
        for (int p = 0; p < word_len; p++) begin
          r = $urandom_range(99);
          if (r < 3) begin
            send_request(FUNC_UNUSED, letter_t'($urandom_range(31)),
                         letter_t'($urandom_range(31)),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
          end else if (r < 5) begin
            send_request(FUNC_EDGE, pick_letter(), pick_letter(),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
          end else if (r < 6) begin
            send_request(FUNC_CLEAR, pick_letter(), pick_letter(),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
          end
          src  = pick_letter();
          last = (p == word_len - 1);
          leq  = last ? ($urandom_range(99) < 85) : 1'($urandom_range(1));
          send_request(FUNC_QUERY, src, pick_target(src), last, leq);
        end
      end
    end
  endtask

  initial begin
    int waited;
    mismatches       = 0;
    idle_pct         = 0;
    request_count    = 0;
    model_edges      = '0;
    model_reach      = '0;
    model_stale      = 1'b1;
    model_word_ok    = 1'b1;
    model_edge_count = '0;
    rst           = 1'b1;
    start         = 1'b0;
    func          = FUNC_EDGE;
    source_letter = '0;
    target_letter = '0;
    last_pair     = 1'b0;
    lengths_equal = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_graph();
    test_chain_reachability();
    test_out_of_range_and_unused();
    test_clear_mid_word();
    test_failed_word();
    test_edge_count_saturation();

    idle_pct = 0;
    run_random_bursts(290);
    idle_pct = 46;
    run_random_bursts(290);
    idle_pct = 33;
    run_random_bursts(290);
    start = 1'b0;

    // Drain: a last query may still sit behind a closure rebuild.
    waited = 0;
    while (verdict_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (verdict_q.size() != 0) begin
      report_mismatch($sformatf("%0d verdicts never strobed", verdict_q.size()));
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
